// ----- rtl/core/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the longest prefix match table
// Table depth, port width, request/response payloads and the record that
// travels down the chain of route cells.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int ENTRIES   = 16;
  localparam int PORT_BITS = 4;

  localparam int SLOT_W     = 4;
  localparam int OUT_PORT_W = 4;
  localparam int ADDR_W     = 32;
  // cell index must cover both the table depth and the slot field
  localparam int CELL_IDX_W = ($clog2(ENTRIES) > SLOT_W) ? $clog2(ENTRIES) : SLOT_W;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [SLOT_W-1:0]     slot;
    logic                  entry_valid;
    logic [ADDR_W-1:0]     entry_dest;
    logic [ADDR_W-1:0]     entry_mask;
    logic [OUT_PORT_W-1:0] entry_port;
    logic [ADDR_W-1:0]     lookup_addr;
  } lpm_req_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_PORT_W-1:0] out_port;
    logic [ADDR_W-1:0]     best_mask;
  } lpm_rsp_t;

  // request plus the best match found so far in earlier cells
  typedef struct packed {
    lpm_req_t             req;
    logic                 found;
    logic [ADDR_W-1:0]    win_mask;
    logic [PORT_BITS-1:0] win_port;
  } lpm_flow_t;

endpackage

// ----- rtl/core/lpm_cell.sv -----
// ----------------------------------------------------------------------------
// lpm_cell: one route slot of the table
// Holds one entry, takes writes addressed to it, and folds its match into
// the running best result of a lookup before handing it to the next cell.
// ----------------------------------------------------------------------------
module lpm_cell
  import lpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [CELL_IDX_W-1:0] index,
  input  logic                  in_valid,
  input  lpm_flow_t             in_flow,
  output logic                  out_valid,
  output lpm_flow_t             out_flow
);

  logic                 entry_vld;
  logic [ADDR_W-1:0]    entry_dest;
  logic [ADDR_W-1:0]    entry_mask;
  logic [PORT_BITS-1:0] entry_port;

  logic      wr;
  logic      match;
  logic      better;
  lpm_flow_t flow_next;

  assign wr = in_valid && advance && (in_flow.req.mode == MODE_WRITE) &&
              (CELL_IDX_W'(in_flow.req.slot) == index);

  assign match = entry_vld && (in_flow.req.mode == MODE_LOOKUP) &&
                 ((in_flow.req.lookup_addr & entry_mask) == (entry_dest & entry_mask));

  // strict compare keeps the lower slot on equal masks
  assign better = match && (!in_flow.found || (entry_mask > in_flow.win_mask));

  always_comb begin
    flow_next = in_flow;
    if (better) begin
      flow_next.found    = 1'b1;
      flow_next.win_mask = entry_mask;
      flow_next.win_port = entry_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else if (wr) begin
      entry_vld <= in_flow.req.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && in_flow.req.entry_valid) begin
      entry_dest <= in_flow.req.entry_dest;
      entry_mask <= in_flow.req.entry_mask;
      entry_port <= PORT_BITS'(in_flow.req.entry_port);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flow <= flow_next;
    end
  end

endmodule

// ----- rtl/core/longest_prefix_match_table_core.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_table_core: IPv4 longest prefix match route table
// A chain of route cells, one per slot, that writes and looks up routes.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_ready carries a request: mode 0 writes or clears one
//   slot, mode 1 looks up lookup_addr. rsp/rsp_valid/rsp_ready returns one
//   response per request, in request order; writes answer with hit 0.
//   Each request walks the chain of ENTRIES cells, each cell registering it
//   in turn on its way to rsp_valid. A new request is taken every cycle
//   while the output does not stall; throughput is then one request per
//   cycle. Writes and lookups move together,
//   so a lookup sees exactly the writes accepted before it.
//   The last cell's register is the output register. When the receiver
//   stalls with a response waiting, the whole chain holds and req_ready
//   drops; it resumes in the cycle rsp_ready rises.
//   Reset clears every slot's valid bit and empties the chain at once;
//   stored destinations, masks and ports are left as they are.
// ----------------------------------------------------------------------------
module longest_prefix_match_table_core
  import lpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lpm_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lpm_rsp_t rsp
);

  logic      advance;
  logic      chain_valid [ENTRIES+1];
  lpm_flow_t chain_flow  [ENTRIES+1];
  lpm_flow_t last_flow;

  assign advance   = !chain_valid[ENTRIES] || rsp_ready;
  assign req_ready = advance;

  assign chain_valid[0]         = req_valid;
  assign chain_flow[0].req      = req;
  assign chain_flow[0].found    = 1'b0;
  assign chain_flow[0].win_mask = '0;
  assign chain_flow[0].win_port = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lpm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .index     (CELL_IDX_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_flow   (chain_flow[i]),
      .out_valid (chain_valid[i+1]),
      .out_flow  (chain_flow[i+1])
    );
  end

  assign last_flow = chain_flow[ENTRIES];
  assign rsp_valid = chain_valid[ENTRIES];

  always_comb begin
    rsp.hit       = last_flow.found;
    rsp.out_port  = last_flow.found ? OUT_PORT_W'(last_flow.win_port) : '0;
    rsp.best_mask = last_flow.found ? last_flow.win_mask : '0;
  end

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("req_ready does not follow output stall");

  a_write_no_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (last_flow.req.mode == MODE_WRITE)) |-> !rsp.hit)
    else $error("write request produced a hit");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

// ----- verif/lpm_checker.sv -----
// ----------------------------------------------------------------------------
// lpm_checker: route table scoreboard for longest_prefix_match_table_core
// Watches both channels, keeps its own copy of the route table, works out
// the response of every accepted request and compares each accepted
// response, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_checker
  import lpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  lpm_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  lpm_rsp_t rsp,
  output int       mismatches,
  output int       answers_due
);

  logic [ENTRIES-1:0]   tbl_on;
  logic [ADDR_W-1:0]    tbl_dst [ENTRIES];
  logic [ADDR_W-1:0]    tbl_msk [ENTRIES];
  logic [PORT_BITS-1:0] tbl_prt [ENTRIES];

  lpm_rsp_t answer_q [$];

  // applies a write to the table copy, or scans it for the best route
  function automatic lpm_rsp_t route_answer(input lpm_req_t r);
    lpm_rsp_t a;
    a = '0;
    if (r.mode == MODE_WRITE) begin
      if (r.slot < ENTRIES) begin
        if (r.entry_valid) begin
          tbl_on[r.slot]  = 1'b1;
          tbl_dst[r.slot] = r.entry_dest;
          tbl_msk[r.slot] = r.entry_mask;
          tbl_prt[r.slot] = r.entry_port[PORT_BITS-1:0];
        end else begin
          // stored route is kept, only the valid bit goes
          tbl_on[r.slot] = 1'b0;
        end
      end
    end else begin
      // strict compare keeps the lowest slot on equal masks
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_on[i] && ((r.lookup_addr & tbl_msk[i]) == (tbl_dst[i] & tbl_msk[i])) &&
            (!a.hit || tbl_msk[i] > a.best_mask)) begin
          a.hit       = 1'b1;
          a.best_mask = tbl_msk[i];
          a.out_port  = tbl_prt[i];
        end
      end
    end
    return a;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lpm_rsp_t want;
    if (rst) begin
      tbl_on = '0;
      answer_q.delete();
    end else begin
      // response side first: it always belongs to an older request
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          $display("%0t: response with no request owed, expected none, actual %0h/%0h/%0h",
                   $time, rsp.hit, rsp.out_port, rsp.best_mask);
        end else begin
          want = answer_q.pop_front();
          check_field("hit", ADDR_W'(want.hit), ADDR_W'(rsp.hit));
          check_field("out_port", ADDR_W'(want.out_port), ADDR_W'(rsp.out_port));
          check_field("best_mask", want.best_mask, rsp.best_mask);
        end
      end
      if (req_valid && req_ready) begin
        answer_q.push_back(route_answer(req));
      end
    end
    answers_due = answer_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for longest_prefix_match_table_core
// Directed route installs, clears and lookups, then random route tables and
// lookups near installed prefixes, under varying sender and receiver idling
// and one long receiver stall. Responses are checked by lpm_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lpm_pkg::*;

  localparam int RX_HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT    = 2000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lpm_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lpm_rsp_t rsp;

  int mismatches;
  int answers_due;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold_trig = 1'b0;
  logic rx_hold_seen = 1'b0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  logic [ADDR_W-1:0] recent_dst [ENTRIES];

  longest_prefix_match_table_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lpm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .answers_due (answers_due)
  );

  always #10 clk = ~clk;

  // receiver: random back-pressure, or a long hold when asked
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rsp_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_trig != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_trig;
      rx_hold_left <= RX_HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : ~32'h0 << (32 - len);
  endfunction

  function automatic lpm_req_t make_write(input logic [SLOT_W-1:0] s, input logic on,
                                          input logic [ADDR_W-1:0] dst, msk,
                                          input logic [OUT_PORT_W-1:0] prt);
    lpm_req_t r;
    r.mode        = MODE_WRITE;
    r.slot        = s;
    r.entry_valid = on;
    r.entry_dest  = dst;
    r.entry_mask  = msk;
    r.entry_port  = prt;
    r.lookup_addr = $urandom;
    return r;
  endfunction

  function automatic lpm_req_t make_lookup(input logic [ADDR_W-1:0] addr);
    lpm_req_t r;
    r.mode        = MODE_LOOKUP;
    r.slot        = SLOT_W'($urandom);
    r.entry_valid = 1'($urandom);
    r.entry_dest  = $urandom;
    r.entry_mask  = $urandom;
    r.entry_port  = OUT_PORT_W'($urandom);
    r.lookup_addr = addr;
    return r;
  endfunction

  task automatic send_req(input lpm_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    if (r.mode == MODE_WRITE) recent_dst[r.slot] = r.entry_dest;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // stop offering until every owed response is back
  task automatic wait_answers();
    req_valid <= 1'b0;
    do @(negedge clk); while (answers_due != 0);
    @(posedge clk);
  endtask

  // mostly routes and addresses near already installed prefixes
  function automatic lpm_req_t random_req();
    lpm_req_t r;
    int pick;
    logic [ADDR_W-1:0] msk;
    logic [ADDR_W-1:0] dst;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 40) begin
      msk = (pick < 85) ? prefix_mask($urandom_range(32)) : $urandom;
      dst = ($urandom_range(1) != 0) ?
            recent_dst[SLOT_W'($urandom_range(ENTRIES - 1))] ^
            ($urandom >> $urandom_range(8, 32)) :
            $urandom;
      r = make_write(SLOT_W'($urandom), ($urandom_range(99) < 85), dst, msk,
                     OUT_PORT_W'($urandom));
    end else if (pick < 75) begin
      r = make_lookup(recent_dst[SLOT_W'($urandom_range(ENTRIES - 1))] ^
                      ($urandom >> $urandom_range(4, 32)));
    end else begin
      r = make_lookup($urandom);
    end
    return r;
  endfunction

  task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                           input bit long_hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 2) rx_hold_trig <= ~rx_hold_trig;
      send_req(random_req());
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) recent_dst[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 16;
    rx_idle_pct <= 79;
    @(posedge clk);

    send_req(make_lookup(32'h0A010203));                          // empty table
    send_req(make_write(4'd0, 1'b1, 32'hDEADBEEF, 32'h0, 4'd3));  // default route
    send_req(make_lookup($urandom));
    send_req(make_write(4'd5, 1'b1, 32'h0A000000, 32'hFF000000, 4'd7));
    send_req(make_write(4'd3, 1'b1, 32'h0A010000, 32'hFFFF0000, 4'd9));
    send_req(make_write(4'd9, 1'b1, 32'h0A01FFFF, 32'hFFFF0000, 4'd12));
    send_req(make_lookup(32'h0A010203));                          // equal masks, slot 3
    send_req(make_lookup(32'h0A7F0000));
    send_req(make_lookup(32'h0B000000));                          // falls to default
    send_req('1);                                                 // all-ones lookup
    send_req(make_write(4'd15, 1'b1, '1, '1, 4'd15));             // host route
    send_req('1);
    send_req(make_write(4'd7, 1'b1, 32'h80000001, 32'h80000001, 4'd1));
    send_req(make_lookup(32'h8FFF0001));                          // non-contiguous mask
    send_req(make_lookup(32'h0A000001));
    send_req(make_write(4'd3, 1'b0, $urandom, $urandom, OUT_PORT_W'($urandom))); // clear
    send_req(make_lookup(32'h0A010203));
    send_req(make_write(4'd9, 1'b1, 32'h0A010000, 32'hFFFFFF00, 4'd4)); // overwrite
    send_req(make_lookup(32'h0A010203));
    send_req('0);                                                 // clears slot 0
    send_req(make_lookup(32'h0B000000));                          // no match
    send_req(make_write(4'd0, 1'b1, 32'h0, 32'h0, 4'd0));
    wait_answers();

    run_phase(540, 16, 79, 1'b0);
    wait_answers();
    run_phase(540, 79, 16, 1'b0);
    wait_answers();
    run_phase(550, 0, 0, 1'b1);
    wait_answers();

    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatches == 0 && answers_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lpm_pkg.sv
rtl/core/lpm_cell.sv
rtl/core/longest_prefix_match_table_core.sv
verif/lpm_checker.sv
verif/testbench.sv
